// ----- hdl/fcpt_pkg.sv -----
// Shared types, codes and constants for the four-channel PWM timer.
package fcpt_pkg;

    localparam int DEF_COUNT_WIDTH  = 16;
    localparam int DEF_NUM_CHANNELS = 4;

    localparam int REG_WIDTH   = 16;    // reload register width
    localparam int DIV_WIDTH   = 17;    // prescale_div register width
    localparam int PCNT_WIDTH  = 16;    // prescaler counter width
    localparam int PWM_WIDTH   = 4;
    localparam int PCT_WIDTH   = 7;     // enough for 0..100
    localparam int PROD_WIDTH  = REG_WIDTH + PCT_WIDTH;

    // floor(p / 100) == (p * RECIP_100) >> RECIP_SHIFT, exact for p < 2**23
    localparam int RECIP_SHIFT = 30;
    localparam int RECIP_WIDTH = 24;
    localparam logic [RECIP_WIDTH-1:0] RECIP_100 = 24'd10737419;
    localparam int QPROD_WIDTH = PROD_WIDTH + RECIP_WIDTH;

    localparam logic [REG_WIDTH-1:0] DUTY_FULL = 16'd100;

    localparam logic [DIV_WIDTH-1:0] DIV_MIN = 17'd1;
    localparam logic [DIV_WIDTH-1:0] DIV_MAX = 17'd65536;

    // command codes
    localparam logic [1:0] CMD_TICK        = 2'd0;
    localparam logic [1:0] CMD_SET_COMPARE = 2'd1;
    localparam logic [1:0] CMD_SET_DUTY    = 2'd2;

    // configuration register indexes
    localparam logic CFG_PRESCALE_DIV = 1'b0;
    localparam logic CFG_RELOAD       = 1'b1;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_BAD_DUTY    = 2'd1,
        ST_BAD_COMPARE = 2'd2
    } t_status;

    // what an item does to the timer state
    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_TICK = 2'd1,
        OP_LOAD = 2'd2
    } t_op;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [1:0]  channel;
        logic [15:0] value;
    } t_in_item;

    typedef struct packed {
        logic [3:0] pwm_out;
        logic [1:0] status;
    } t_out_item;

    typedef struct packed {
        t_op        op;
        logic [1:0] channel;
        t_status    status;
    } t_upd;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_stage_en;

endpackage

// ----- hdl/fcpt_front.sv -----
// Front pipeline: command decode, range checks and duty-to-compare arithmetic.
module fcpt_front import fcpt_pkg::*; #(
    parameter int COUNT_WIDTH  = DEF_COUNT_WIDTH,
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
    input  logic                   i_clk,
    input  t_stage_en              i_en,
    input  t_in_item               i_item,
    input  logic [REG_WIDTH-1:0]   i_reload,
    output t_upd                   o_upd,
    output logic [COUNT_WIDTH-1:0] o_cmp_val
);

    // stage 1
    t_in_item r_s1;

    logic                  s1_ch_ok;
    logic                  s1_is_cmp;
    logic                  s1_is_duty;
    t_op                   s1_op;
    t_status               s1_status;
    logic [PROD_WIDTH-1:0] s1_prod;

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_s1 <= i_item;
        end
    end

    assign s1_ch_ok   = 32'(r_s1.channel) < NUM_CHANNELS;
    assign s1_is_cmp  = (r_s1.cmd == CMD_SET_COMPARE) && s1_ch_ok;
    assign s1_is_duty = (r_s1.cmd == CMD_SET_DUTY) && s1_ch_ok;
    assign s1_prod    = PROD_WIDTH'(i_reload) * PROD_WIDTH'(r_s1.value[PCT_WIDTH-1:0]);

    always_comb begin
        s1_op     = OP_NONE;
        s1_status = ST_OK;
        if (r_s1.cmd == CMD_TICK) begin
            s1_op = OP_TICK;
        end else if (s1_is_cmp) begin
            if (r_s1.value > i_reload) begin
                s1_status = ST_BAD_COMPARE;
            end else begin
                s1_op = OP_LOAD;
            end
        end else if (s1_is_duty) begin
            if (r_s1.value > DUTY_FULL) begin
                s1_status = ST_BAD_DUTY;
            end else begin
                s1_op = OP_LOAD;
            end
        end
    end

    // stage 2
    t_upd                   r_s2_upd;
    logic                   r_s2_duty;
    logic [REG_WIDTH-1:0]   r_s2_val;
    logic [PROD_WIDTH-1:0]  r_s2_prod;

    logic [QPROD_WIDTH-1:0] s2_qprod;
    logic [REG_WIDTH-1:0]   s2_quot;
    logic [REG_WIDTH-1:0]   s2_sel;

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_s2_upd.op      <= s1_op;
            r_s2_upd.channel <= r_s1.channel;
            r_s2_upd.status  <= s1_status;
            r_s2_duty        <= s1_is_duty;
            r_s2_val         <= r_s1.value;
            r_s2_prod        <= s1_prod;
        end
    end

    assign s2_qprod = QPROD_WIDTH'(r_s2_prod) * QPROD_WIDTH'(RECIP_100);
    assign s2_quot  = s2_qprod[RECIP_SHIFT +: REG_WIDTH];
    assign s2_sel   = r_s2_duty ? s2_quot : r_s2_val;

    // stage 3
    t_upd                   r_s3_upd;
    logic [COUNT_WIDTH-1:0] r_s3_cmp;

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_s3_upd <= r_s2_upd;
            r_s3_cmp <= COUNT_WIDTH'(s2_sel);
        end
    end

    assign o_upd     = r_s3_upd;
    assign o_cmp_val = r_s3_cmp;

endmodule

// ----- hdl/fcpt_core.sv -----
// Timer state: prescaler, main counter, compare preloads and active compares.
module fcpt_core import fcpt_pkg::*; #(
    parameter int COUNT_WIDTH  = DEF_COUNT_WIDTH,
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_fire,
    input  t_upd                   i_upd,
    input  logic [COUNT_WIDTH-1:0] i_cmp_val,
    input  logic [DIV_WIDTH-1:0]   i_prescale_div,
    input  logic [REG_WIDTH-1:0]   i_reload,
    output logic [PWM_WIDTH-1:0]   o_pwm
);

    localparam int CMP_W = (COUNT_WIDTH > REG_WIDTH) ? COUNT_WIDTH : REG_WIDTH;

    logic [PCNT_WIDTH-1:0]  r_pcount, n_pcount;
    logic [COUNT_WIDTH-1:0] r_main,   n_main;
    logic [COUNT_WIDTH-1:0] r_preload [NUM_CHANNELS];
    logic [COUNT_WIDTH-1:0] n_preload [NUM_CHANNELS];
    logic [COUNT_WIDTH-1:0] r_active  [NUM_CHANNELS];
    logic [COUNT_WIDTH-1:0] n_active  [NUM_CHANNELS];

    logic [DIV_WIDTH-1:0]   eff_div;
    logic [DIV_WIDTH-1:0]   pc_inc;
    logic                   at_top;

    // zero acts as one, anything past the prescaler range saturates
    always_comb begin
        if (i_prescale_div == '0) begin
            eff_div = DIV_MIN;
        end else if (i_prescale_div > DIV_MAX) begin
            eff_div = DIV_MAX;
        end else begin
            eff_div = i_prescale_div;
        end
    end

    assign pc_inc = DIV_WIDTH'(r_pcount) + DIV_WIDTH'(1);
    assign at_top = CMP_W'(r_main) >= CMP_W'(i_reload);

    always_comb begin
        n_pcount = r_pcount;
        n_main   = r_main;
        if (i_fire) begin
            case (i_upd.op)
                OP_TICK: begin
                    if (pc_inc >= eff_div) begin
                        n_pcount = '0;
                        n_main   = at_top ? '0 : r_main + COUNT_WIDTH'(1);
                    end else begin
                        n_pcount = pc_inc[PCNT_WIDTH-1:0];
                    end
                end
                OP_LOAD: begin
                    n_pcount = '0;
                    n_main   = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcount <= '0;
            r_main   <= '0;
        end else begin
            r_pcount <= n_pcount;
            r_main   <= n_main;
        end
    end

    genvar g;
    generate
        for (g = 0; g < NUM_CHANNELS; g++) begin : g_chan
            logic load_here;
            logic update_evt;

            assign update_evt = i_fire && (i_upd.op == OP_LOAD);
            assign load_here  = update_evt && (i_upd.channel == 2'(g));

            always_comb begin
                n_preload[g] = load_here ? i_cmp_val : r_preload[g];
                n_active[g]  = update_evt ? n_preload[g] : r_active[g];
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_preload[g] <= '0;
                    r_active[g]  <= '0;
                end else begin
                    r_preload[g] <= n_preload[g];
                    r_active[g]  <= n_active[g];
                end
            end
        end

        for (g = 0; g < PWM_WIDTH; g++) begin : g_pwm
            if (g < NUM_CHANNELS) begin : g_on
                assign o_pwm[g] = r_main < r_active[g];
            end else begin : g_off
                assign o_pwm[g] = 1'b0;
            end
        end
    endgenerate

endmodule

// ----- hdl/four_channel_pwm_timer.sv -----
// Top level of the four-channel edge-aligned PWM timer.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries commands:
//   a tick advances the prescaler and main counter, set-compare and
//   set-duty write a channel's preload and then force an update event
//   (counters clear, all preloads copied to the active compares).
//   Output channel (o_out_valid / i_out_ready / o_out_data) returns one
//   result per command: the PWM bits after that command and a status code.
//   Configuration (prescale_div, reload) is written through i_cfg_* while
//   the block is idle; writes take effect at once.
// Timing:
//   One transfer per cycle is sustained while i_out_ready is high. The
//   duty path sets the depth: reload*percent is multiplied in stage 1,
//   divided by 100 with a reciprocal multiply in stage 2, and the timer
//   state is updated as an item leaves stage 3.
// Reset (i_rst_n low, synchronous): pipeline empties, counters and
//   compares clear, prescale_div = 1, reload = 65535.
// Stall: when i_out_ready is low the result holds; upstream stages keep
//   filling until all are full, then o_in_ready drops.
module four_channel_pwm_timer import fcpt_pkg::*; #(
    parameter int COUNT_WIDTH  = DEF_COUNT_WIDTH,
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // command input
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_data,
    // result output
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_data,
    // configuration writes
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [DIV_WIDTH-1:0] i_cfg_data
);

    // configuration registers
    logic [DIV_WIDTH-1:0] r_prescale_div;
    logic [REG_WIDTH-1:0] r_reload;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prescale_div <= DIV_MIN;
            r_reload       <= '1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PRESCALE_DIV: r_prescale_div <= i_cfg_data;
                CFG_RELOAD:       r_reload       <= i_cfg_data[REG_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    // pipeline occupancy; each stage moves when the next one has room
    logic      r_v1, r_v2, r_v3, r_v4;
    logic      s1_ready, s2_ready, s3_ready, s4_ready;
    logic      fire;
    t_stage_en stage_en;

    assign s4_ready = !r_v4 || i_out_ready;
    assign s3_ready = !r_v3 || s4_ready;
    assign s2_ready = !r_v2 || s3_ready;
    assign s1_ready = !r_v1 || s2_ready;

    assign stage_en.s1 = s1_ready && i_in_valid;
    assign stage_en.s2 = s2_ready && r_v1;
    assign stage_en.s3 = s3_ready && r_v2;
    assign fire        = s4_ready && r_v3;   // state update point

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (s1_ready) r_v1 <= i_in_valid;
            if (s2_ready) r_v2 <= r_v1;
            if (s3_ready) r_v3 <= r_v2;
            if (s4_ready) r_v4 <= r_v3;
        end
    end

    t_upd                   upd;
    logic [COUNT_WIDTH-1:0] cmp_val;
    logic [PWM_WIDTH-1:0]   pwm;

    fcpt_front #(
        .COUNT_WIDTH  (COUNT_WIDTH),
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_front (
        .i_clk     (i_clk),
        .i_en      (stage_en),
        .i_item    (i_in_data),
        .i_reload  (r_reload),
        .o_upd     (upd),
        .o_cmp_val (cmp_val)
    );

    fcpt_core #(
        .COUNT_WIDTH  (COUNT_WIDTH),
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_upd          (upd),
        .i_cmp_val      (cmp_val),
        .i_prescale_div (r_prescale_div),
        .i_reload       (r_reload),
        .o_pwm          (pwm)
    );

    // result register: status is latched here, PWM bits come from the
    // state registers, which hold while this result waits
    t_status r_status;

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_status <= upd.status;
        end
    end

    assign o_in_ready         = s1_ready;
    assign o_out_valid        = r_v4;
    assign o_out_data.pwm_out = pwm;
    assign o_out_data.status  = r_status;

endmodule

// ----- verif/tb_four_channel_pwm_timer.sv -----
// Testbench for four_channel_pwm_timer: directed and random commands checked against a predictor.
`timescale 1ns / 100ps

module tb_four_channel_pwm_timer;
    import fcpt_pkg::*;

    // cmd 3 is not decoded by the block: no state change, status OK
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    // cycles without any transfer before the run is declared hung
    localparam int HANG_LIMIT = 5000;
    // pipeline depth plus margin, used before config writes and at the end
    localparam int SETTLE_CYCLES = 6;
    localparam int MAX_REPORTS = 40;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    t_in_item             i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out_item            o_out_data;
    logic                 i_cfg_we = 1'b0;
    logic                 i_cfg_index = 1'b0;
    logic [DIV_WIDTH-1:0] i_cfg_data = '0;

    four_channel_pwm_timer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 20 ns clock
    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Timer shadow: registers, counters and compares as the block holds them
    // ------------------------------------------------------------------
    logic [DIV_WIDTH-1:0] tmr_div = DIV_MIN;
    logic [REG_WIDTH-1:0] tmr_reload = 16'hFFFF;
    logic [15:0]          tmr_presc = '0;
    logic [15:0]          tmr_count = '0;
    logic [15:0]          cmp_preload [4] = '{default: '0};
    logic [15:0]          cmp_active  [4] = '{default: '0};

    t_out_item pending_results [$];

    int errors      = 0;
    int n_ticks     = 0;
    int n_compares  = 0;
    int n_duties    = 0;
    int n_unused    = 0;
    int n_rejected  = 0;
    int n_results   = 0;
    int idle_cycles = 0;

    // stimulus knobs
    bit send_gaps_on     = 1'b1;
    bit ready_stalls_on  = 1'b1;
    int stall_left       = 0;
    int stall_pick;

    // Advance or load the timer shadow for one command, return its result
    function automatic t_out_item timer_step(t_in_item cmd_item);
        t_out_item            res;
        logic [DIV_WIDTH-1:0] div_eff;
        logic [16:0]          presc_next;
        logic [31:0]          duty_prod;
        bit                   load_event;

        res        = '0;
        res.status = ST_OK;
        load_event = 1'b0;
        case (cmd_item.cmd)
            CMD_TICK: begin
                // zero divides like one, anything past 65536 saturates
                if (tmr_div < DIV_MIN)      div_eff = DIV_MIN;
                else if (tmr_div > DIV_MAX) div_eff = DIV_MAX;
                else                        div_eff = tmr_div;
                presc_next = {1'b0, tmr_presc} + 17'd1;
                if (presc_next >= div_eff) begin
                    tmr_presc = '0;
                    // also catches a count left above a lowered reload
                    if (tmr_count >= tmr_reload) tmr_count = '0;
                    else                         tmr_count = tmr_count + 16'd1;
                end else begin
                    tmr_presc = presc_next[15:0];
                end
            end
            CMD_SET_COMPARE: begin
                if (cmd_item.value > tmr_reload) begin
                    res.status = ST_BAD_COMPARE;
                end else begin
                    cmp_preload[cmd_item.channel] = cmd_item.value;
                    load_event = 1'b1;
                end
            end
            CMD_SET_DUTY: begin
                if (cmd_item.value > DUTY_FULL) begin
                    res.status = ST_BAD_DUTY;
                end else begin
                    // floor(reload * pct / 100), exact
                    duty_prod = 32'(tmr_reload) * 32'(cmd_item.value);
                    cmp_preload[cmd_item.channel] = 16'(duty_prod / 32'd100);
                    load_event = 1'b1;
                end
            end
            default: ;
        endcase

        // accepted load: restart the period and take all preloads
        if (load_event) begin
            tmr_presc = '0;
            tmr_count = '0;
            for (int i = 0; i < 4; i++) cmp_active[i] = cmp_preload[i];
        end

        for (int i = 0; i < PWM_WIDTH; i++)
            res.pwm_out[i] = (tmr_count < cmp_active[i]);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: config writes, input transfers, result check
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_PRESCALE_DIV) tmr_div = i_cfg_data;
                else                                 tmr_reload = i_cfg_data[REG_WIDTH-1:0];
            end

            if (i_in_valid && o_in_ready) begin
                want = timer_step(i_in_data);
                pending_results.push_back(want);
                case (i_in_data.cmd)
                    CMD_TICK:        n_ticks++;
                    CMD_SET_COMPARE: n_compares++;
                    CMD_SET_DUTY:    n_duties++;
                    default:         n_unused++;
                endcase
                if (want.status != ST_OK) n_rejected++;
            end

            if (o_out_valid && i_out_ready) begin
                n_results++;
                if (pending_results.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: result transfer with nothing expected (got %h)",
                                 $time, o_out_data);
                end else begin
                    want = pending_results.pop_front();
                    if (o_out_data.pwm_out !== want.pwm_out) begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%0t: pwm_out expected %b, actual %b",
                                     $time, want.pwm_out, o_out_data.pwm_out);
                    end
                    if (o_out_data.status !== want.status) begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%0t: status expected %0d, actual %0d",
                                     $time, want.status, o_out_data.status);
                    end
                end
            end
        end
    end

    // Result side backpressure: mostly ready, short stalls, now and then a long one
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left  = stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (!ready_stalls_on) begin
            i_out_ready <= 1'b1;
        end else begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 65) begin
                i_out_ready <= 1'b1;
            end else if (stall_pick < 94) begin
                i_out_ready <= 1'b0;
                stall_left  = $urandom_range(0, 2);
            end else begin
                i_out_ready <= 1'b0;
                stall_left  = $urandom_range(6, 30);
            end
        end
    end

    // Hang detector: any transfer restarts the count
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= HANG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, HANG_LIMIT);
            $display("tb_four_channel_pwm_timer: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers (always entered just after a rising edge)
    // ------------------------------------------------------------------

    // One command transfer, then maybe an idle gap
    task automatic send_cmd(input logic [1:0] cmd, input logic [1:0] chan,
                            input logic [15:0] val);
        int gap;
        int pick;
        i_in_valid <= 1'b1;
        i_in_data  <= '{cmd: cmd, channel: chan, value: val};
        do @(posedge i_clk); while (!o_in_ready);
        gap = 0;
        if (send_gaps_on) begin
            pick = $urandom_range(0, 99);
            if (pick >= 90)      gap = $urandom_range(8, 40);
            else if (pick >= 55) gap = $urandom_range(1, 3);
        end
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop sending and wait until every result is back and the pipe is empty
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [DIV_WIDTH-1:0] data);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic set_timer(input logic [DIV_WIDTH-1:0] div, input logic [15:0] top);
        write_reg(CFG_PRESCALE_DIV, div);
        write_reg(CFG_RELOAD, {1'b0, top});
    endtask

    task automatic send_ticks(input int count);
        for (int i = 0; i < count; i++)
            send_cmd(CMD_TICK, 2'($urandom), 16'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Out of reset all compares are zero: outputs stay low while counting
    task automatic test_reset_defaults();
        send_ticks(3);
    endtask

    // Every command, accepted and rejected duties, at the reset period
    task automatic test_commands();
        set_timer(17'd1, 16'hFFFF);
        send_cmd(CMD_SET_COMPARE, 2'd0, 16'd0);
        send_cmd(CMD_SET_COMPARE, 2'd1, 16'hFFFF);
        send_cmd(CMD_SET_DUTY,    2'd2, 16'd100);
        send_cmd(CMD_SET_DUTY,    2'd3, 16'd50);
        send_cmd(CMD_SET_DUTY,    2'd0, 16'd101);      // just over full duty
        send_cmd(CMD_SET_DUTY,    2'd1, 16'hFFFF);
        send_cmd(CMD_UNUSED,      2'd3, 16'hFFFF);
        send_ticks(2);
    endtask

    // Zero reload: count pinned at zero, only a zero compare gets in
    task automatic test_reload_zero();
        set_timer(17'd1, 16'd0);
        send_cmd(CMD_SET_COMPARE, 2'd1, 16'd1);
        send_cmd(CMD_SET_COMPARE, 2'd1, 16'd0);
        send_cmd(CMD_SET_DUTY,    2'd2, 16'd100);
        send_ticks(3);
    endtask

    // Reload lowered under a running count: next step wraps to zero
    task automatic test_count_above_reload();
        set_timer(17'd1, 16'hFFFF);
        send_cmd(CMD_SET_COMPARE, 2'd0, 16'd10);
        send_gaps_on = 1'b0;
        send_ticks(20);
        send_gaps_on = 1'b1;
        write_reg(CFG_RELOAD, 17'd5);
        send_ticks(3);
        send_cmd(CMD_SET_COMPARE, 2'd3, 16'd6);         // now above reload
    endtask

    // Full duty holds the output low only at the top count, across a wrap;
    // then full-scale compare and duty at the widest period
    task automatic test_full_period();
        set_timer(17'd1, 16'd3);
        send_cmd(CMD_SET_DUTY, 2'd0, 16'd100);
        send_ticks(5);
        set_timer(17'd1, 16'hFFFF);
        send_cmd(CMD_SET_COMPARE, 2'd1, 16'hFFFF);
        send_cmd(CMD_SET_DUTY,    2'd2, 16'd100);
        send_gaps_on    = 1'b0;
        ready_stalls_on = 1'b0;
        send_ticks(8);
        send_gaps_on    = 1'b1;
        ready_stalls_on = 1'b1;
    endtask

    // Divider of zero acts as one; oversize divider saturates, count holds
    task automatic test_prescaler_limits();
        set_timer(17'd0, 16'd4);
        send_cmd(CMD_SET_COMPARE, 2'd0, 16'd2);
        send_ticks(6);
        set_timer(17'h1FFFF, 16'd3);
        send_cmd(CMD_SET_COMPARE, 2'd0, 16'd1);
        send_gaps_on    = 1'b0;
        ready_stalls_on = 1'b0;
        send_ticks(20);
        send_gaps_on    = 1'b1;
        ready_stalls_on = 1'b1;
    endtask

    // Random command mix over a series of timer settings
    task automatic test_random_traffic();
        logic [DIV_WIDTH-1:0] divs [7] = '{17'd1, 17'd1, 17'd2, 17'd0, 17'd3,
                                           17'd65536, 17'd1};
        logic [15:0]          tops [7] = '{16'hFFFF, 16'd1, 16'd7, 16'd12, 16'd0,
                                           16'd2, 16'd40};
        int          pick;
        int          span;
        logic [1:0]  chan;
        logic [15:0] val;

        for (int ph = 0; ph < 7; ph++) begin
            set_timer(divs[ph], tops[ph]);
            for (int i = 0; i < 96; i++) begin
                // every 36 items: maybe a stretch with no idling at all
                if (i % 36 == 0) begin
                    send_gaps_on    = ($urandom_range(0, 3) != 0);
                    ready_stalls_on = ($urandom_range(0, 3) != 0);
                end
                pick = $urandom_range(0, 99);
                chan = 2'($urandom);
                if (pick < 60) begin
                    send_cmd(CMD_TICK, chan, 16'($urandom));
                end else if (pick < 76) begin
                    span = int'(tmr_reload) + 2;
                    if (span > 65535) span = 65535;
                    if ($urandom_range(0, 3) == 0) val = 16'($urandom);
                    else                           val = 16'($urandom_range(0, span));
                    send_cmd(CMD_SET_COMPARE, chan, val);
                end else if (pick < 93) begin
                    if ($urandom_range(0, 4) == 0) val = 16'($urandom);
                    else                           val = 16'($urandom_range(0, 103));
                    send_cmd(CMD_SET_DUTY, chan, val);
                end else begin
                    send_cmd(CMD_UNUSED, chan, 16'($urandom));
                end
            end
        end
        send_gaps_on    = 1'b1;
        ready_stalls_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_commands();
        test_reload_zero();
        test_count_above_reload();
        test_full_period();
        test_prescaler_limits();
        test_random_traffic();

        wait_idle();
        repeat (10) @(posedge i_clk);

        $display("Covered %0d ticks, %0d set-compare, %0d set-duty, %0d unused commands",
                 n_ticks, n_compares, n_duties, n_unused);
        $display("  %0d rejected; %0d results checked, %0d left pending",
                 n_rejected, n_results, pending_results.size());
        if (errors == 0 && pending_results.size() == 0) begin
            $display("tb_four_channel_pwm_timer: done, clean");
        end else begin
            $display("tb_four_channel_pwm_timer: done, errors");
        end
        $finish;
    end

endmodule

// ----- four_channel_pwm_timer.f -----
hdl/fcpt_pkg.sv
hdl/fcpt_front.sv
hdl/fcpt_core.sv
hdl/four_channel_pwm_timer.sv
verif/tb_four_channel_pwm_timer.sv
